@@ rtl/dpcbc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpcbc_pkg
// Types and constants shared by the depth point cloud box counter.
// ----------------------------------------------------------------------------
package dpcbc_pkg;

  // Field widths
  localparam int unsigned DepthW  = 16;
  localparam int unsigned ColourW = 24;
  localparam int unsigned IdxW    = 3;
  localparam int unsigned SelW    = 3;
  localparam int unsigned BoundW  = 16;
  localparam int unsigned CoordW  = 10;
  localparam int unsigned DimW    = 11;
  localparam int unsigned DensW   = 5;
  localparam int unsigned ActW    = 4;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned CountW  = 20;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 11;

  // Stream word widths (tdata padded to whole bytes)
  localparam int unsigned InDataW  = 64;
  localparam int unsigned OutDataW = 88;

  localparam logic [CountW-1:0] CountMax = '1;
  localparam logic [DimW-1:0]   GridMax  = 11'd1024;

  // Number of bounds held per box
  localparam int unsigned NumBounds = 6;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_PIXEL = 2'd1,
    CMD_BOUND = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_POINT = 2'd0,
    KIND_COUNT = 2'd1,
    KIND_ACK   = 2'd2,
    KIND_DROP  = 2'd3
  } kind_e;

  // Bound slots within a box
  localparam int unsigned BndMinX = 0;
  localparam int unsigned BndMaxX = 1;
  localparam int unsigned BndMinY = 2;
  localparam int unsigned BndMaxY = 3;
  localparam int unsigned BndMinD = 4;
  localparam int unsigned BndMaxD = 5;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegWidth   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegHeight  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegDensity = 3'd2;
  localparam logic [CfgIdxW-1:0] RegColour  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegActive  = 3'd4;

endpackage : dpcbc_pkg
`default_nettype wire

@@ rtl/depth_point_cloud_box_counter.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// depth_point_cloud_box_counter
// Depth stream to point cloud converter with per-box point counters.
// ----------------------------------------------------------------------------
// Each input word carries a command in tuser: start frame, pixel sample,
// bound write or count read. Every command yields exactly one output word.
// Pixel samples arrive in raster order; the block tracks the grid position
// itself, stepping x and y by the density up to the target size, and emits
// x, y, depth and optionally the colour bytes. The point is tested against
// every active box in parallel (inclusive min/max on x, y, depth) and each
// hit raises that box's 20-bit saturating count. Samples after the last point
// of a frame come back as dropped words until the next start frame. The block
// takes one word per clock while the output words are taken: an input register
// and an output register surround a single pass of compare and update logic,
// which turns the word held in the input register into the output word. While
// the output word waits, the input register takes one more word and then holds
// the input off until the output word is taken. Write configuration only while
// no word is in flight.
// ----------------------------------------------------------------------------
module depth_point_cloud_box_counter
  import dpcbc_pkg::*;
#(
  parameter int unsigned NUM_BOXES = 8
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Configuration write port
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgW-1:0]     cfg_wdata_i,
  // Input stream
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // [15:0] depth, [39:16] packed_colour, [42:40] box_index,
  // [45:43] bound_select, [61:46] bound_value, [63:62] zero
  input  wire logic [InDataW-1:0]  s_axis_tdata_i,
  // [1:0] cmd
  input  wire logic [1:0]          s_axis_tuser_i,
  // Output stream
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  // [9:0] point_x, [19:10] point_y, [35:20] point_depth, [43:36] red,
  // [51:44] green, [59:52] blue, [60] colour_valid, [80:61] box_count,
  // [87:81] zero
  output logic [OutDataW-1:0]      m_axis_tdata_o,
  // [1:0] kind
  output logic [1:0]               m_axis_tuser_o,
  // frame_last
  output logic                     m_axis_tlast_o
);

  localparam int unsigned LoopW = 6;

  // Configuration registers
  logic [DimW-1:0]  width_q, height_q;
  logic [DensW-1:0] density_q;
  logic             colour_q;
  logic [ActW-1:0]  active_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= 11'd640;
      height_q  <= 11'd480;
      density_q <= 5'd1;
      colour_q  <= 1'b0;
      active_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegWidth:   width_q   <= cfg_wdata_i;
        RegHeight:  height_q  <= cfg_wdata_i;
        RegDensity: density_q <= cfg_wdata_i[DensW-1:0];
        RegColour:  colour_q  <= cfg_wdata_i[0];
        RegActive:  active_q  <= cfg_wdata_i[ActW-1:0];
        default: ;
      endcase
    end
  end

  // Input register stage
  logic                  s1_v_q;
  cmd_e                  s1_cmd_q;
  logic [DepthW-1:0]     s1_depth_q;
  logic [ColourW-1:0]    s1_colour_q;
  logic [IdxW-1:0]       s1_idx_q;
  logic [SelW-1:0]       s1_sel_q;
  logic [BoundW-1:0]     s1_val_q;

  logic out_v_q;
  logic out_load;
  logic proc;
  logic s_fire;

  // Advance the output register when empty or being drained
  assign out_load        = !out_v_q || m_axis_tready_i;
  assign proc            = s1_v_q && out_load;
  assign s_axis_tready_o = !s1_v_q || out_load;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s_fire) begin
      s1_v_q <= 1'b1;
    end else if (proc) begin
      s1_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      s1_cmd_q    <= cmd_e'(s_axis_tuser_i);
      s1_depth_q  <= s_axis_tdata_i[15:0];
      s1_colour_q <= s_axis_tdata_i[39:16];
      s1_idx_q    <= s_axis_tdata_i[42:40];
      s1_sel_q    <= s_axis_tdata_i[45:43];
      s1_val_q    <= s_axis_tdata_i[61:46];
    end
  end

  // Frame and box state
  logic [CoordW-1:0] cursor_x_q, cursor_x_d;
  logic [CoordW-1:0] cursor_y_q, cursor_y_d;
  logic              done_q, done_d;
  logic [BoundW-1:0] bounds_q [NUM_BOXES][NumBounds];
  logic [BoundW-1:0] bounds_d [NUM_BOXES][NumBounds];
  logic [CountW-1:0] counts_q [NUM_BOXES];
  logic [CountW-1:0] counts_d [NUM_BOXES];

  // Result word built this cycle
  kind_e             kind_d;
  logic [CoordW-1:0] px_d, py_d;
  logic [DepthW-1:0] pdep_d;
  logic [ByteW-1:0]  red_d, green_d, blue_d;
  logic              cvalid_d;
  logic              last_d;
  logic [CountW-1:0] bcount_d;

  logic [DimW-1:0]   w_eff, h_eff;
  logic [DensW-1:0]  step;
  logic [DimW-1:0]   nx, ny;
  logic [BoundW-1:0] cx_ext, cy_ext;

  always_comb begin
    // Clamp the grid size and step into their meaningful ranges
    w_eff = (width_q == '0) ? DimW'(1) : ((width_q > GridMax) ? GridMax : width_q);
    h_eff = (height_q == '0) ? DimW'(1) : ((height_q > GridMax) ? GridMax : height_q);
    step  = (density_q == '0) ? DensW'(1) : density_q;
    nx    = {1'b0, cursor_x_q} + DimW'(step);
    ny    = {1'b0, cursor_y_q} + DimW'(step);
    cx_ext = BoundW'(cursor_x_q);
    cy_ext = BoundW'(cursor_y_q);

    cursor_x_d = cursor_x_q;
    cursor_y_d = cursor_y_q;
    done_d     = done_q;
    bounds_d   = bounds_q;
    counts_d   = counts_q;

    kind_d   = KIND_ACK;
    px_d     = '0;
    py_d     = '0;
    pdep_d   = '0;
    red_d    = '0;
    green_d  = '0;
    blue_d   = '0;
    cvalid_d = 1'b0;
    last_d   = 1'b0;
    bcount_d = '0;

    case (s1_cmd_q)
      CMD_START: begin
        // Clear counts and cursor, keep bounds
        for (int b = 0; b < NUM_BOXES; b++) begin
          counts_d[b] = '0;
        end
        cursor_x_d = '0;
        cursor_y_d = '0;
        done_d     = 1'b0;
        kind_d     = KIND_ACK;
      end
      CMD_PIXEL: begin
        if (done_q) begin
          kind_d = KIND_DROP;
        end else begin
          kind_d = KIND_POINT;
          px_d   = cursor_x_q;
          py_d   = cursor_y_q;
          pdep_d = s1_depth_q;
          if (colour_q) begin
            red_d    = s1_colour_q[23:16];
            green_d  = s1_colour_q[15:8];
            blue_d   = s1_colour_q[7:0];
            cvalid_d = 1'b1;
          end
          // Parallel inclusive box tests, one counter per box
          for (int b = 0; b < NUM_BOXES; b++) begin
            if ((LoopW'(b) < LoopW'(active_q)) &&
                (cx_ext >= bounds_q[b][BndMinX]) && (cx_ext <= bounds_q[b][BndMaxX]) &&
                (cy_ext >= bounds_q[b][BndMinY]) && (cy_ext <= bounds_q[b][BndMaxY]) &&
                (s1_depth_q >= bounds_q[b][BndMinD]) &&
                (s1_depth_q <= bounds_q[b][BndMaxD]) &&
                (counts_q[b] != CountMax)) begin
              counts_d[b] = counts_q[b] + CountW'(1);
            end
          end
          // Advance the raster cursor, flag the final point
          if (nx >= w_eff) begin
            cursor_x_d = '0;
            if (ny >= h_eff) begin
              last_d = 1'b1;
              done_d = 1'b1;
            end else begin
              cursor_y_d = ny[CoordW-1:0];
            end
          end else begin
            cursor_x_d = nx[CoordW-1:0];
          end
        end
      end
      CMD_BOUND: begin
        // Out-of-range box or slot is ignored but acknowledged
        for (int b = 0; b < NUM_BOXES; b++) begin
          for (int s = 0; s < NumBounds; s++) begin
            if ((LoopW'(b) == LoopW'(s1_idx_q)) && (SelW'(s) == s1_sel_q)) begin
              bounds_d[b][s] = s1_val_q;
            end
          end
        end
        kind_d = KIND_ACK;
      end
      CMD_READ: begin
        kind_d = KIND_COUNT;
        for (int b = 0; b < NUM_BOXES; b++) begin
          if (LoopW'(b) == LoopW'(s1_idx_q)) begin
            bcount_d = counts_q[b];
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_x_q <= '0;
      cursor_y_q <= '0;
      done_q     <= 1'b0;
      for (int b = 0; b < NUM_BOXES; b++) begin
        counts_q[b] <= '0;
        for (int s = 0; s < NumBounds; s++) begin
          bounds_q[b][s] <= '0;
        end
      end
    end else if (proc) begin
      cursor_x_q <= cursor_x_d;
      cursor_y_q <= cursor_y_d;
      done_q     <= done_d;
      counts_q   <= counts_d;
      bounds_q   <= bounds_d;
    end
  end

  // Output register: hold until taken
  logic [OutDataW-1:0] out_data_q;
  kind_e               out_kind_q;
  logic                out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_load) begin
      out_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      out_kind_q <= kind_d;
      out_last_q <= last_d;
      out_data_q <= {7'b0, bcount_d, cvalid_d, blue_d, green_d, red_d, pdep_d, py_d, px_d};
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule : depth_point_cloud_box_counter
`default_nettype wire
